>>> hdl/all_pairs_shortest_path_defines.svh
// Assertion macros shared by the all-pairs shortest path RTL.
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define APSP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define APSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define APSP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define APSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/apsp_pkg.sv
// Types, constants and the microcode table of the all-pairs shortest path block.
package apsp_pkg;

    localparam int NODE_FIELD_W = 6;
    localparam int WEIGHT_W     = 20;
    localparam int COUNT_W      = 7;
    localparam int DIST_W       = 26;
    localparam int ENTRY_W      = DIST_W + 1;

    // Bit 26 alone marks an unreachable entry; finite sums clamp to DIST_MAX.
    localparam logic [ENTRY_W-1:0] DIST_INF = {1'b1, {DIST_W{1'b0}}};
    localparam logic [ENTRY_W-1:0] DIST_MAX = {1'b0, {DIST_W{1'b1}}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_UNDIRECTED = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        cmd_t                    command;
        logic [NODE_FIELD_W-1:0] from_node;
        logic [NODE_FIELD_W-1:0] to_node;
        logic [WEIGHT_W-1:0]     weight;
    } req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reachable;
    } rsp_t;

    // Matrix read port selection.
    typedef enum logic [1:0] {
        RD_EDGE  = 2'd0,   // A = (from,to), B = (to,from)
        RD_IK    = 2'd1,   // A = (i,k)
        RD_KJ_IJ = 2'd2    // A = (k,j), B = (i,j)
    } rd_sel_t;

    // Matrix write selection.
    typedef enum logic [2:0] {
        WR_NONE    = 3'd0,
        WR_CLEAR   = 3'd1,
        WR_EDGE_AB = 3'd2,
        WR_EDGE_BA = 3'd3,
        WR_RELAX   = 3'd4
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_ZERO = 2'd1,
        CNT_INC  = 2'd2
    } cnt_op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [3:0] {
        C_NONE         = 4'd0,
        C_ALWAYS       = 4'd1,
        C_DISPATCH     = 4'd2,
        C_RSP_BUSY     = 4'd3,
        C_OUT_RANGE    = 4'd4,
        C_NOT_UNDIR    = 4'd5,
        C_DIK_INF      = 4'd6,
        C_J_NOT_LAST   = 4'd7,
        C_I_NOT_LAST   = 4'd8,
        C_K_NOT_LAST   = 4'd9,
        C_CLR_NOT_LAST = 4'd10
    } cond_t;

    typedef logic [3:0] upc_t;

    // Program addresses.
    localparam upc_t U_IDLE = 4'd0;
    localparam upc_t U_CLR  = 4'd1;
    localparam upc_t U_E0   = 4'd2;
    localparam upc_t U_E1   = 4'd3;
    localparam upc_t U_E2   = 4'd4;
    localparam upc_t U_RI   = 4'd5;
    localparam upc_t U_RL   = 4'd6;
    localparam upc_t U_RJ   = 4'd7;
    localparam upc_t U_RW   = 4'd8;
    localparam upc_t U_NI   = 4'd9;
    localparam upc_t U_NK   = 4'd10;
    localparam upc_t U_Q0   = 4'd11;
    localparam upc_t U_Q1   = 4'd12;
    localparam upc_t U_LAST = U_Q1;

    typedef struct packed {
        logic    req_ready;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        cnt_op_t i_op;
        cnt_op_t j_op;
        cnt_op_t k_op;
        logic    clr_inc;
        logic    dik_load;
        logic    rsp_load;
        cond_t   cond;
        upc_t    target;
        logic    ret;      // on a false condition return to idle instead of falling through
    } ctrl_t;

    typedef struct packed {
        logic in_range;
        logic dik_inf;
        logic j_last;
        logic i_last;
        logic k_last;
        logic clr_last;
        logic rsp_busy;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        req_ready: 1'b0,
        rd_sel:    RD_EDGE,
        wr_sel:    WR_NONE,
        i_op:      CNT_HOLD,
        j_op:      CNT_HOLD,
        k_op:      CNT_HOLD,
        clr_inc:   1'b0,
        dik_load:  1'b0,
        rsp_load:  1'b0,
        cond:      C_NONE,
        target:    U_IDLE,
        ret:       1'b1
    };

    // Entry point of each command.
    function automatic upc_t dispatch(input cmd_t cmd);
        upc_t t;
        unique case (cmd)
            CMD_CLEAR: t = U_CLR;
            CMD_EDGE:  t = U_E0;
            CMD_RUN:   t = U_RI;
            CMD_QUERY: t = U_Q0;
            default:   t = U_IDLE;
        endcase
        return t;
    endfunction

    // Microcode ROM: one control word per step.
    function automatic ctrl_t ucode(input upc_t upc);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (upc)
            U_IDLE: begin
                w.req_ready = 1'b1;
                w.i_op      = CNT_ZERO;
                w.j_op      = CNT_ZERO;
                w.k_op      = CNT_ZERO;
                w.cond      = C_DISPATCH;
            end
            U_CLR: begin
                w.wr_sel  = WR_CLEAR;
                w.clr_inc = 1'b1;
                w.cond    = C_CLR_NOT_LAST;
                w.target  = U_CLR;
            end
            U_E0: begin
                w.rd_sel = RD_EDGE;
                w.cond   = C_OUT_RANGE;
                w.target = U_IDLE;
                w.ret    = 1'b0;
            end
            U_E1: begin
                w.wr_sel = WR_EDGE_AB;
                w.cond   = C_NOT_UNDIR;
                w.target = U_IDLE;
                w.ret    = 1'b0;
            end
            U_E2: begin
                w.wr_sel = WR_EDGE_BA;
            end
            U_RI: begin
                w.rd_sel = RD_IK;
                w.ret    = 1'b0;
            end
            U_RL: begin
                w.dik_load = 1'b1;
                w.cond     = C_DIK_INF;
                w.target   = U_NI;
                w.ret      = 1'b0;
            end
            U_RJ: begin
                w.rd_sel = RD_KJ_IJ;
                w.ret    = 1'b0;
            end
            U_RW: begin
                w.wr_sel = WR_RELAX;
                w.j_op   = CNT_INC;
                w.cond   = C_J_NOT_LAST;
                w.target = U_RJ;
                w.ret    = 1'b0;
            end
            U_NI: begin
                w.i_op   = CNT_INC;
                w.cond   = C_I_NOT_LAST;
                w.target = U_RI;
                w.ret    = 1'b0;
            end
            U_NK: begin
                w.k_op   = CNT_INC;
                w.cond   = C_K_NOT_LAST;
                w.target = U_RI;
            end
            U_Q0: begin
                w.rd_sel = RD_EDGE;
                w.cond   = C_RSP_BUSY;
                w.target = U_Q0;
                w.ret    = 1'b0;
            end
            U_Q1: begin
                w.rsp_load = 1'b1;
            end
            default: begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/apsp_ram.sv
// Generic RAM: one write port, two registered read ports.
module apsp_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> hdl/apsp_dp.sv
// Datapath: request registers, loop counters, distance matrix, relax unit, result register.
`include "all_pairs_shortest_path_defines.svh"

module apsp_dp #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  apsp_pkg::ctrl_t                   ctrl,
    input  logic                              req_accept,
    input  apsp_pkg::req_t                    req,
    input  logic [apsp_pkg::COUNT_W-1:0]      node_limit,
    input  logic [$clog2(MAX_NODES)-1:0]      last_node,
    output apsp_pkg::status_t                 stat,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output apsp_pkg::rsp_t                    rsp
);

    import apsp_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * NODE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ?
        {WEIGHT_W{1'b1}} : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    logic [NODE_W-1:0]   from_reg, to_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                in_range_reg;
    logic [NODE_W-1:0]   i_reg, j_reg, k_reg;
    logic [ADDR_W-1:0]   clr_reg;
    logic [ENTRY_W-1:0]  dik_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic                in_range;
    logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b, wr_addr;
    logic [ENTRY_W-1:0]  rd_data_a, rd_data_b, wr_data;
    logic                wr_en;
    logic [ENTRY_W-1:0]  weight_entry, relax_sum, sum;

    function automatic logic [NODE_W-1:0] step_cnt(input cnt_op_t op,
                                                   input logic [NODE_W-1:0] v,
                                                   input logic last);
        logic [NODE_W-1:0] r;
        unique case (op)
            CNT_ZERO: r = '0;
            CNT_INC:  r = last ? '0 : v + 1'b1;
            default:  r = v;
        endcase
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] min_entry(input logic [ENTRY_W-1:0] a,
                                                     input logic [ENTRY_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    assign in_range = ({1'b0, req.from_node} < node_limit) &&
                      ({1'b0, req.to_node} < node_limit);

    // Latch the request and the pivot entry d[i][k]; both endpoints must fall below the node count.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            from_reg   <= NODE_W'(req.from_node);
            to_reg     <= NODE_W'(req.to_node);
            weight_reg <= req.weight & WEIGHT_MASK;
        end
        if (ctrl.dik_load)
        begin
            dik_reg <= rd_data_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            if (req_accept)
            begin
                in_range_reg <= in_range;
            end
            i_reg <= step_cnt(ctrl.i_op, i_reg, stat.i_last);
            j_reg <= step_cnt(ctrl.j_op, j_reg, stat.j_last);
            k_reg <= step_cnt(ctrl.k_op, k_reg, stat.k_last);
            if (ctrl.clr_inc)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_IK:
            begin
                rd_addr_a = {i_reg, k_reg};
                rd_addr_b = {i_reg, j_reg};
            end
            RD_KJ_IJ:
            begin
                rd_addr_a = {k_reg, j_reg};
                rd_addr_b = {i_reg, j_reg};
            end
            default:
            begin
                rd_addr_a = {from_reg, to_reg};
                rd_addr_b = {to_reg, from_reg};
            end
        endcase
    end

    // Saturating add; d[i][k] is known finite here.
    assign weight_entry = ENTRY_W'(weight_reg);
    assign sum = {1'b0, dik_reg[DIST_W-1:0]} + {1'b0, rd_data_a[DIST_W-1:0]};
    assign relax_sum = rd_data_a[ENTRY_W-1] ? DIST_INF :
                       (sum[ENTRY_W-1] ? DIST_MAX : sum);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = {i_reg, j_reg};
        wr_data = min_entry(relax_sum, rd_data_b);
        unique case (ctrl.wr_sel)
            WR_CLEAR:
            begin
                wr_addr = clr_reg;
                wr_data = (clr_reg[ADDR_W-1:NODE_W] == clr_reg[NODE_W-1:0]) ? '0 : DIST_INF;
            end
            WR_EDGE_AB:
            begin
                wr_addr = {from_reg, to_reg};
                wr_data = min_entry(weight_entry, rd_data_a);
            end
            WR_EDGE_BA:
            begin
                wr_addr = {to_reg, from_reg};
                wr_data = min_entry(weight_entry, rd_data_b);
            end
            WR_RELAX:
            begin
                wr_addr = {i_reg, j_reg};
                wr_data = min_entry(relax_sum, rd_data_b);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    apsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_matrix (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // Result register: load on query completion, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rsp_load)
        begin
            if (in_range_reg && !rd_data_a[ENTRY_W-1])
            begin
                rsp_reg.distance  <= rd_data_a[DIST_W-1:0];
                rsp_reg.reachable <= 1'b1;
            end
            else
            begin
                rsp_reg.distance  <= '0;
                rsp_reg.reachable <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stat.in_range = in_range_reg;
    assign stat.dik_inf  = rd_data_a[ENTRY_W-1];
    assign stat.j_last   = (j_reg == last_node);
    assign stat.i_last   = (i_reg == last_node);
    assign stat.k_last   = (k_reg == last_node);
    assign stat.clr_last = &clr_reg;
    assign stat.rsp_busy = rsp_valid_reg && rsp_stall;

    `APSP_ASSERT_IMPLIES(a_load_into_empty, clk, rst_n, ctrl.rsp_load, !rsp_valid_reg, "result loaded over a pending result")
    `APSP_ASSERT_IMPLIES(a_relax_finite_pivot, clk, rst_n, ctrl.wr_sel == WR_RELAX, !dik_reg[ENTRY_W-1], "relaxation through an unreachable pivot")
    `APSP_ASSERT_IMPLIES(a_unreachable_zero, clk, rst_n, rsp_valid_reg && !rsp_reg.reachable, rsp_reg.distance == '0, "unreachable result with nonzero distance")

endmodule

>>> hdl/apsp_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
`include "all_pairs_shortest_path_defines.svh"

module apsp_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  apsp_pkg::cmd_t    command,
    input  apsp_pkg::status_t stat,
    input  logic              undirected,
    output apsp_pkg::ctrl_t   ctrl
);

    import apsp_pkg::*;

    upc_t upc_reg, upc_next;
    logic taken;

    assign ctrl = ucode(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:       taken = 1'b1;
            C_RSP_BUSY:     taken = stat.rsp_busy;
            C_OUT_RANGE:    taken = !stat.in_range;
            C_NOT_UNDIR:    taken = !undirected;
            C_DIK_INF:      taken = stat.dik_inf;
            C_J_NOT_LAST:   taken = !stat.j_last;
            C_I_NOT_LAST:   taken = !stat.i_last;
            C_K_NOT_LAST:   taken = !stat.k_last;
            C_CLR_NOT_LAST: taken = !stat.clr_last;
            default:        taken = 1'b0;
        endcase

        priority if (ctrl.cond == C_DISPATCH)
        begin
            upc_next = req_valid ? dispatch(command) : upc_reg;
        end
        else if (taken)
        begin
            upc_next = ctrl.target;
        end
        else if (ctrl.ret)
        begin
            upc_next = U_IDLE;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // Start with the matrix clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    `APSP_ASSERT_ALWAYS(a_upc_in_program, clk, rst_n, upc_reg <= U_LAST, "step counter left the program")

endmodule

>>> hdl/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path block: configuration, handshake and units.
//
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  apsp_pkg::req_t  command, from_node, to_node, weight
// rsp      out  rsp_valid / rsp_stall  apsp_pkg::rsp_t  distance, reachable
// cfg      in   cfg_wr_en              cfg_index, cfg_data
//
// Steps: clear writes every matrix entry; load edge reads, writes (from,to), then
//   (to,from) in undirected mode only, and stops after the read when a node is out of
//   range; query waits for the result register, then loads it; run takes a read then
//   a write step per inner update on the dual-read RAM and skips unreachable-pivot rows.
// Reset: the matrix is cleared by a sweep over every entry with req_stall high.
// Stalls: rsp_stall holds a result while new requests are still accepted; only a
//   following query waits for the result register to drain.
module all_pairs_shortest_path #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  apsp_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output apsp_pkg::rsp_t                 rsp,
    input  logic                           cfg_wr_en,
    input  apsp_pkg::cfg_idx_t             cfg_index,
    input  logic [apsp_pkg::COUNT_W-1:0]   cfg_data
);

    import apsp_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);

    logic [COUNT_W-1:0] node_count_reg;
    logic               undirected_reg;
    logic [COUNT_W-1:0] node_limit;
    logic [NODE_W-1:0]  last_node;
    logic               req_accept;
    ctrl_t              ctrl;
    status_t            stat;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd64;
            undirected_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data;
                CFG_UNDIRECTED: undirected_reg <= cfg_data[0];
                default:        node_count_reg <= node_count_reg;
            endcase
        end
    end

    // Effective node count: zero acts as one, anything above MAX_NODES clamps.
    always_comb
    begin
        priority if (node_count_reg == '0)
        begin
            node_limit = COUNT_W'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            node_limit = COUNT_W'(MAX_NODES);
        end
        else
        begin
            node_limit = node_count_reg;
        end
    end

    assign last_node = NODE_W'(node_limit - 1'b1);

    // Take a request only at the idle step of the program.
    assign req_stall  = !ctrl.req_ready;
    assign req_accept = req_valid && ctrl.req_ready;

    apsp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .command    (req.command),
        .stat       (stat),
        .undirected (undirected_reg),
        .ctrl       (ctrl)
    );

    apsp_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .req_accept (req_accept),
        .req        (req),
        .node_limit (node_limit),
        .last_node  (last_node),
        .stat       (stat),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

>>> sim/all_pairs_shortest_path_tb.sv
// Testbench for the all-pairs shortest path block: predicts each request and checks results.
`timescale 1ns / 100ps

module all_pairs_shortest_path_tb;
    import apsp_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int MAX_NODES    = 64;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_t                rsp;
    logic                cfg_wr_en;
    cfg_idx_t            cfg_index;
    logic [COUNT_W-1:0]  cfg_data;

    all_pairs_shortest_path #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the distance matrix and the two registers.
    logic [ENTRY_W-1:0]  dist_tbl [MAX_NODES][MAX_NODES];
    logic [COUNT_W-1:0]  shadow_node_count;
    logic                shadow_undirected;

    // Distances still owed by the block, oldest first.
    rsp_t                expected_rsp [$];

    int                  error_count   = 0;
    int                  items_sent    = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;

    // Long receiver hold-off: the test bumps hold_seq, the stall process counts it out.
    int                  hold_len  = 0;
    int                  hold_seq  = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow matrix arithmetic
    // ------------------------------------------------------------------

    // Node count as the block uses it: 0 reads as 1, above the matrix size clamps.
    function automatic int nodes_active();
        if (shadow_node_count == '0)
            return 1;
        if (int'(shadow_node_count) > MAX_NODES)
            return MAX_NODES;
        return int'(shadow_node_count);
    endfunction

    task automatic reset_matrix();
        for (int r = 0; r < MAX_NODES; r++)
            for (int c = 0; c < MAX_NODES; c++)
                dist_tbl[r][c] = (r == c) ? '0 : DIST_INF;
    endtask

    // Infinity absorbs; a finite sum clamps at DIST_MAX and stays reachable.
    function automatic logic [ENTRY_W-1:0] path_sum(input logic [ENTRY_W-1:0] a,
                                                     input logic [ENTRY_W-1:0] b);
        logic [ENTRY_W:0] s;
        if (a >= DIST_INF || b >= DIST_INF)
            return DIST_INF;
        s = a + b;
        if (s > DIST_MAX)
            return DIST_MAX;
        return s[ENTRY_W-1:0];
    endfunction

    task automatic tighten_entry(input int r, input int c, input logic [ENTRY_W-1:0] w);
        if (w < dist_tbl[r][c])
            dist_tbl[r][c] = w;
    endtask

    // Pivot over k, skip rows whose pivot entry is still unreachable.
    task automatic relax_matrix(input int n);
        logic [ENTRY_W-1:0] dik;
        logic [ENTRY_W-1:0] s;
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
            begin
                dik = dist_tbl[i][k];
                if (dik >= DIST_INF)
                    continue;
                for (int j = 0; j < n; j++)
                begin
                    s = path_sum(dik, dist_tbl[k][j]);
                    if (s < dist_tbl[i][j])
                        dist_tbl[i][j] = s;
                end
            end
    endtask

    // Apply one accepted request to the shadow state; queue the answer of a query.
    task automatic predict_request(input req_t r);
        int   n;
        int   a;
        int   b;
        rsp_t e;
        n = nodes_active();
        a = int'(r.from_node);
        b = int'(r.to_node);
        case (r.command)
            CMD_CLEAR:
                reset_matrix();
            CMD_EDGE:
                if (a < n && b < n)
                begin
                    tighten_entry(a, b, ENTRY_W'(r.weight));
                    if (shadow_undirected)
                        tighten_entry(b, a, ENTRY_W'(r.weight));
                end
            CMD_RUN:
                relax_matrix(n);
            CMD_QUERY:
            begin
                e = '0;
                if (a < n && b < n && dist_tbl[a][b] < DIST_INF)
                begin
                    e.distance  = dist_tbl[a][b][DIST_W-1:0];
                    e.reachable = 1'b1;
                end
                expected_rsp.insert(expected_rsp.size(), e);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: stall generation and checking
    // ------------------------------------------------------------------

    // Drive rsp_stall: a requested hold-off first, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare every accepted result with the oldest outstanding distance.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result with no query outstanding: distance %0d reachable %0b",
                       rsp.distance, rsp.reachable);
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.distance !== want.distance)
                begin
                    $error("distance: expected %0d, actual %0d", want.distance, rsp.distance);
                    error_count++;
                end
                if (rsp.reachable !== want.reachable)
                begin
                    $error("reachable: expected %0b, actual %0b",
                           want.reachable, rsp.reachable);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until accepted, then predict it. Valid stays high
    // on return so back-to-back requests need no extra edge.
    task automatic send_request(input cmd_t cmd, input int unsigned from_n,
                                input int unsigned to_n, input int unsigned weight_v);
        req_t r;
        int   gap;
        r.command   = cmd;
        r.from_node = NODE_FIELD_W'(from_n);
        r.to_node   = NODE_FIELD_W'(to_n);
        r.weight    = WEIGHT_W'(weight_v);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_request(r);
        items_sent++;
    endtask

    task automatic wait_all_results();
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Fence the block: a query finishes only after every earlier command, so once
    // its answer is in, the sequencer is back in idle.
    task automatic drain_block();
        send_request(CMD_QUERY, 0, 0, 0);
        req_valid <= 1'b0;
        wait_all_results();
        repeat (4) @(posedge clk);
    endtask

    // Write one register; only call while the block is idle.
    task automatic write_register(input cfg_idx_t idx, input logic [COUNT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NODE_COUNT: shadow_node_count = value;
            CFG_UNDIRECTED: shadow_undirected = value[0];
        endcase
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Matrix after the reset sweep: zero diagonal, infinity elsewhere.
    task automatic test_reset_state();
        set_idling(0, 0);
        send_request(CMD_QUERY, 0, 0, 0);
        send_request(CMD_QUERY, 63, 62, 0);
        send_request(CMD_QUERY, 0, 63, 0);
        send_request(CMD_QUERY, 63, 63, 0);
    endtask

    // Parallel edges keep the least, a self edge leaves the diagonal at zero,
    // undirected mode fills the mirror, and the maximum weight adds up.
    task automatic test_edge_rules();
        set_idling(31, 31);
        send_request(CMD_EDGE, 0, 1, 100);
        send_request(CMD_EDGE, 0, 1, 40);
        send_request(CMD_EDGE, 0, 1, 70);
        send_request(CMD_EDGE, 5, 5, 7);
        send_request(CMD_EDGE, 1, 63, 20'hFFFFF);
        send_request(CMD_RUN, 63, 0, 20'hFFFFF);
        send_request(CMD_QUERY, 1, 0, 0);
        send_request(CMD_QUERY, 5, 5, 0);
        send_request(CMD_QUERY, 0, 63, 0);
        send_request(CMD_QUERY, 63, 0, 0);
    endtask

    // Directed mode: the mirror entry stays unreachable.
    task automatic test_directed_mode();
        set_idling(0, 0);
        drain_block();
        write_register(CFG_UNDIRECTED, '0);
        write_register(CFG_NODE_COUNT, 7'd8);
        send_request(CMD_CLEAR, 0, 0, 0);
        send_request(CMD_EDGE, 2, 3, 5);
        send_request(CMD_EDGE, 3, 4, 6);
        send_request(CMD_RUN, 0, 0, 0);
        send_request(CMD_QUERY, 2, 4, 0);
        send_request(CMD_QUERY, 4, 2, 0);
    endtask

    // Out-of-range nodes are ignored or read as unreachable; a node count of zero
    // acts as one node and one above the matrix size as the full matrix.
    task automatic test_node_limits();
        send_request(CMD_EDGE, 9, 2, 1);
        send_request(CMD_QUERY, 9, 2, 0);
        drain_block();
        write_register(CFG_NODE_COUNT, '0);
        send_request(CMD_QUERY, 0, 0, 0);
        send_request(CMD_QUERY, 0, 1, 0);
        drain_block();
        write_register(CFG_NODE_COUNT, 7'd127);
        send_request(CMD_QUERY, 2, 3, 0);
        send_request(CMD_QUERY, 3, 2, 0);
        send_request(CMD_QUERY, 63, 63, 0);
    endtask

    // Shrinking the node count hides entries without touching them; clear wipes
    // the whole matrix, nodes outside the count included.
    task automatic test_clear_scope();
        drain_block();
        write_register(CFG_UNDIRECTED, 7'd1);
        write_register(CFG_NODE_COUNT, 7'(MAX_NODES));
        send_request(CMD_EDGE, 40, 50, 9);
        drain_block();
        write_register(CFG_NODE_COUNT, 7'd8);
        send_request(CMD_QUERY, 40, 50, 0);
        drain_block();
        write_register(CFG_NODE_COUNT, 7'(MAX_NODES));
        send_request(CMD_QUERY, 50, 40, 0);
        drain_block();
        write_register(CFG_NODE_COUNT, 7'd8);
        send_request(CMD_CLEAR, 0, 0, 0);
        drain_block();
        write_register(CFG_NODE_COUNT, 7'(MAX_NODES));
        send_request(CMD_QUERY, 40, 50, 0);
    endtask

    // Hold the receiver off while queries keep coming: the result register fills
    // and the next query must back up into req_stall. Then pause the sender until
    // every answer is in.
    task automatic test_pressure();
        set_idling(0, 0);
        drain_block();
        hold_len <= 400;
        hold_seq <= hold_seq + 1;
        repeat (12)
            send_request(CMD_QUERY, $urandom_range(63), $urandom_range(63), 0);
        req_valid <= 1'b0;
        wait_all_results();
    endtask

    // ------------------------------------------------------------------
    // Random graphs
    // ------------------------------------------------------------------

    // Mostly small weights so that detours matter, now and then the full range.
    function automatic int unsigned pick_weight();
        if ($urandom_range(99) < 30)
            return $urandom() & 32'hFFFFF;
        return $urandom_range(0, 60);
    endfunction

    // Drop in a fully random request now and then.
    task automatic maybe_noise();
        if ($urandom_range(99) < 12)
            send_request(cmd_t'($urandom_range(3)), $urandom_range(63),
                         $urandom_range(63), $urandom() & 32'hFFFFF);
    endtask

    // One graph: pick a setting, clear, load edges, relax, query. Now and then
    // skip the clear or the run to get broken sequences.
    task automatic random_graph_round();
        int          n;
        int unsigned pick;
        drain_block();
        pick = $urandom_range(99);
        if (pick < 6)
            write_register(CFG_NODE_COUNT, '0);
        else if (pick < 12)
            write_register(CFG_NODE_COUNT, 7'd1);
        else if (pick < 16)
            write_register(CFG_NODE_COUNT, 7'd127);
        else if (pick < 20)
            write_register(CFG_NODE_COUNT, 7'(MAX_NODES));
        else
            write_register(CFG_NODE_COUNT, 7'($urandom_range(2, 12)));
        write_register(CFG_UNDIRECTED, 7'($urandom_range(127)));
        n = nodes_active();
        if ($urandom_range(99) < 85)
            send_request(CMD_CLEAR, $urandom_range(63), $urandom_range(63), pick_weight());
        repeat ($urandom_range(3, 8))
        begin
            maybe_noise();
            send_request(CMD_EDGE, $urandom_range(n - 1), $urandom_range(n - 1),
                         pick_weight());
        end
        if ($urandom_range(99) < 85)
            send_request(CMD_RUN, $urandom_range(63), $urandom_range(63), pick_weight());
        repeat ($urandom_range(3, 6))
        begin
            maybe_noise();
            send_request(CMD_QUERY, $urandom_range(n - 1), $urandom_range(n - 1),
                         pick_weight());
        end
    endtask

    // Four idling phases of at least ten requests each.
    task automatic test_random_graphs();
        int target;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(65, 0);
                2: set_idling(0, 65);
                default: set_idling(31, 31);
            endcase
            target = items_sent + 10;
            while (items_sent < target)
                random_graph_round();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data  = '0;
        shadow_node_count = 7'(MAX_NODES);
        shadow_undirected = 1'b1;
        reset_matrix();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_edge_rules();
        test_directed_mode();
        test_node_limits();
        test_clear_scope();
        test_pressure();
        test_random_graphs();

        // Fence out any trailing run, then let the pipeline settle.
        set_idling(0, 0);
        drain_block();
        repeat (20) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            $error("results still outstanding at end: %0d", expected_rsp.size());
            error_count++;
        end
        if (error_count == 0)
            $display("all_pairs_shortest_path_tb: done, clean");
        else
            $display("all_pairs_shortest_path_tb: done, errors");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("all_pairs_shortest_path_tb: done, errors");
        $finish;
    end

endmodule

>>> all_pairs_shortest_path.f
+incdir+hdl
hdl/apsp_pkg.sv
hdl/apsp_ram.sv
hdl/apsp_dp.sv
hdl/apsp_seq.sv
hdl/all_pairs_shortest_path.sv
sim/all_pairs_shortest_path_tb.sv
